// ===== rtl/core/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants of the client heartbeat table
// Field widths, result codes, register indexes, the queue item and the
// configuration bundle used by the front end, the back end and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

   localparam int SLOTS_DEFAULT = 16;

   // Field widths
   localparam int MODE_W   = 2;
   localparam int ID_W     = 32;
   localparam int STAMP_W  = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int STEP_W   = 16;
   localparam int PERIOD_W = 31;
   localparam int CD_W     = 33;

   // Register port
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [1:0] REG_TICK_STEP   = 2'd0;
   localparam logic [1:0] REG_PING_PERIOD = 2'd1;
   localparam logic [1:0] REG_PING_STAMP  = 2'd2;

   localparam logic [STEP_W-1:0]   TICK_STEP_RESET   = 16'd1000;
   localparam logic [PERIOD_W-1:0] PING_PERIOD_RESET = 31'd50000;
   localparam logic [STAMP_W-1:0]  PING_STAMP_RESET  = 32'd1234;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PING   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DROP   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ALREADY   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd4;

   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_REGISTER   = 2'd1,
      OP_UNREGISTER = 2'd2,
      OP_PONG       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SCAN,
      B_DONE
   } back_state_type;

   typedef struct packed {
      op_type               op;
      logic [ID_W-1:0]      client_id;
      logic [STAMP_W-1:0]   pong_stamp;
   } item_type;

   typedef struct packed {
      logic [STEP_W-1:0]    tick_step;
      logic [PERIOD_W-1:0]  ping_period;
      logic [STAMP_W-1:0]   ping_stamp;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/cht_if.sv =====
// ----------------------------------------------------------------------------
// cht_if: request and response channels of the client heartbeat table
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface cht_req_if;
   import cht_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [ID_W-1:0]      client_id;
   logic [STAMP_W-1:0]   pong_stamp;

   modport source (output valid, output mode, output client_id, output pong_stamp,
                   input ready);
   modport sink   (input valid, input mode, input client_id, input pong_stamp,
                   output ready);
endinterface

interface cht_rsp_if;
   import cht_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [ID_W-1:0]      target_id;
   logic [STATUS_W-1:0]  status;
   logic                 last;

   modport source (output valid, output kind, output target_id, output status,
                   output last, input ready);
   modport sink   (input valid, input kind, input target_id, input status,
                   input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cht_ram.sv =====
// ----------------------------------------------------------------------------
// cht_ram: generic simple dual-port RAM
// One write port, one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, hold when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cht_front.sv =====
// ----------------------------------------------------------------------------
// cht_front: request intake of the client heartbeat table
// Accepts request items, classifies them by mode and holds them in a
// two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_front (
   input  wire logic      clock,
   input  wire logic      reset,
   cht_req_if.sink        req,
   output cht_pkg::item_type q_item,
   output logic           q_valid,
   input  wire logic      q_pop
);
   import cht_pkg::*;

   localparam int QDEPTH = 2;

   item_type    entry_ff [QDEPTH];
   item_type    new_item;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff,  count_in;
   logic        push;
   logic        pop;

   // Classify the incoming item
   always_comb begin
      new_item.client_id  = req.client_id;
      new_item.pong_stamp = req.pong_stamp;
      unique case (req.mode)
         OP_TICK:       new_item.op = OP_TICK;
         OP_REGISTER:   new_item.op = OP_REGISTER;
         OP_UNREGISTER: new_item.op = OP_UNREGISTER;
         default:       new_item.op = OP_PONG;
      endcase
   end

   assign req.ready = (count_ff != 2'(QDEPTH));
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];
   assign push      = req.valid && req.ready;
   assign pop       = q_pop && q_valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cht_back.sv =====
// ----------------------------------------------------------------------------
// cht_back: table engine of the client heartbeat table
// Takes one queued item at a time, walks the slots one entry a cycle unless a
// result waits; updates ids, pending stamps and countdown; drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_back #(
   parameter int SLOTS = cht_pkg::SLOTS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cht_pkg::cfg_type  cfg,
   input  wire cht_pkg::item_type q_item,
   input  wire logic              q_valid,
   output logic                   q_pop,
   cht_rsp_if.source              rsp
);
   import cht_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   back_state_type      state_ff, state_in;
   item_type            item_ff, item_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]    ev_idx_ff, ev_idx_in;
   logic                hit_ff, hit_in;
   logic                free_found_ff, free_found_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [CD_W-1:0]     cd_ff, cd_in;
   logic [CD_W-1:0]     cd_dec;

   logic [SLOTS-1:0]    id_vld_ff;
   logic [SLOTS-1:0]    pd_vld_ff;
   logic                rd_id_vld_ff;
   logic                rd_pd_vld_ff;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [ID_W-1:0]     id_q;
   logic [STAMP_W-1:0]  pd_q;
   logic [ID_W-1:0]     ev_id;
   logic [STAMP_W-1:0]  ev_pd;

   logic                id_we, pd_we;
   logic [IDX_W-1:0]    id_wa, pd_wa;
   logic [ID_W-1:0]     id_wd;
   logic [STAMP_W-1:0]  pd_wd;

   logic                out_free;
   logic                need_emit;
   logic                ev_done;
   logic                stop;
   logic                issue;
   logic                emit;
   logic [KIND_W-1:0]   emit_kind;
   logic [ID_W-1:0]     emit_target;
   logic [STATUS_W-1:0] emit_status;
   logic                emit_last;

   logic                rsp_valid_ff;
   logic [KIND_W-1:0]   rsp_kind_ff;
   logic [ID_W-1:0]     rsp_target_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_last_ff;

   // Slot tables
   cht_ram #(.WIDTH(ID_W), .DEPTH(SLOTS), .AW(IDX_W)) u_id_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (id_wa),
      .wr_data (id_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (id_q)
   );

   cht_ram #(.WIDTH(STAMP_W), .DEPTH(SLOTS), .AW(IDX_W)) u_pd_ram (
      .clock   (clock),
      .wr_en   (pd_we),
      .wr_addr (pd_wa),
      .wr_data (pd_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (pd_q)
   );

   // Never-written entries read as zero
   assign rd_addr  = rd_idx_ff[IDX_W-1:0];
   assign ev_id    = rd_id_vld_ff ? id_q : '0;
   assign ev_pd    = rd_pd_vld_ff ? pd_q : '0;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign cd_dec   = cd_ff - CD_W'(cfg.tick_step);

   // Sequencer: next state, table writes and results
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      rd_idx_in     = rd_idx_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      hit_in        = hit_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      cd_in         = cd_ff;
      q_pop         = 1'b0;
      rd_en         = 1'b0;
      id_we         = 1'b0;
      id_wa         = ev_idx_ff;
      id_wd         = '0;
      pd_we         = 1'b0;
      pd_wa         = ev_idx_ff;
      pd_wd         = '0;
      need_emit     = 1'b0;
      ev_done       = 1'b0;
      stop          = 1'b0;
      issue         = 1'b0;
      emit          = 1'b0;
      emit_kind     = KIND_STATUS;
      emit_target   = '0;
      emit_status   = ST_OK;
      emit_last     = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               item_in       = q_item;
               rd_idx_in     = '0;
               ev_valid_in   = 1'b0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               state_in      = B_SCAN;
               // Tick: lower the countdown; if it would go negative, reload it and sweep
               if (q_item.op == OP_TICK) begin
                  if (cd_dec[CD_W-1]) begin
                     cd_in = CD_W'(cfg.ping_period);
                  end else begin
                     cd_in    = cd_dec;
                     state_in = B_DONE;
                  end
               end
            end
         end

         B_SCAN: begin
            // Evaluate the entry held on the registered read port
            if (ev_valid_ff) begin
               unique case (item_ff.op)
                  OP_REGISTER: begin
                     if (ev_id == item_ff.client_id) begin
                        hit_in = 1'b1;
                     end
                     if ((ev_id == '0) && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = ev_idx_ff;
                     end
                  end
                  OP_UNREGISTER: begin
                     if (ev_id == item_ff.client_id) begin
                        hit_in = 1'b1;
                        stop   = 1'b1;
                        id_we  = 1'b1;
                     end
                  end
                  OP_PONG: begin
                     if ((ev_id != '0) && (ev_id == item_ff.client_id) &&
                         (ev_pd == item_ff.pong_stamp)) begin
                        hit_in = 1'b1;
                        stop   = 1'b1;
                        pd_we  = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     if (ev_id != '0) begin
                        need_emit = 1'b1;
                        if (out_free) begin
                           emit        = 1'b1;
                           emit_target = ev_id;
                           if (ev_pd != '0) begin
                              emit_kind = KIND_DROP;
                              id_we     = 1'b1;
                           end else begin
                              emit_kind = KIND_PING;
                              pd_we     = 1'b1;
                              pd_wd     = cfg.ping_stamp;
                           end
                        end
                     end
                  end
               endcase
            end

            // Advance the walk unless a result is stuck
            ev_done = ev_valid_ff && !(need_emit && !out_free);
            issue   = !stop && (rd_idx_ff != CNT_W'(SLOTS)) && (!ev_valid_ff || ev_done);
            if (issue) begin
               rd_en       = 1'b1;
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
               ev_idx_in   = rd_idx_ff[IDX_W-1:0];
               ev_valid_in = 1'b1;
            end else if (ev_done) begin
               ev_valid_in = 1'b0;
            end

            if (stop || ((rd_idx_ff == CNT_W'(SLOTS)) && (!ev_valid_ff || ev_done))) begin
               ev_valid_in = 1'b0;
               state_in    = B_DONE;
            end
         end

         B_DONE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               state_in  = B_IDLE;
               unique case (item_ff.op)
                  OP_REGISTER: begin
                     emit_kind   = KIND_ACK;
                     emit_target = item_ff.client_id;
                     if (hit_ff) begin
                        emit_status = ST_ALREADY;
                     end else if (!free_found_ff) begin
                        emit_status = ST_FULL;
                     end else begin
                        emit_status = ST_OK;
                        id_we       = 1'b1;
                        id_wa       = free_idx_ff;
                        id_wd       = item_ff.client_id;
                        pd_we       = 1'b1;
                        pd_wa       = free_idx_ff;
                     end
                  end
                  OP_UNREGISTER: begin
                     emit_kind   = KIND_ACK;
                     emit_target = item_ff.client_id;
                     emit_status = hit_ff ? ST_OK : ST_NOT_FOUND;
                  end
                  OP_PONG: begin
                     emit_kind   = KIND_STATUS;
                     emit_target = item_ff.client_id;
                     emit_status = hit_ff ? ST_OK : ST_UNMATCHED;
                  end
                  OP_TICK: begin
                     emit_kind   = KIND_STATUS;
                     emit_target = '0;
                     emit_status = ST_OK;
                  end
               endcase
            end
         end

         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_IDLE;
         ev_valid_ff <= 1'b0;
         cd_ff       <= CD_W'(PING_PERIOD_RESET);
         id_vld_ff   <= '0;
         pd_vld_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         ev_valid_ff <= ev_valid_in;
         cd_ff       <= cd_in;
         if (id_we) begin
            id_vld_ff[id_wa] <= 1'b1;
         end
         if (pd_we) begin
            pd_vld_ff[pd_wa] <= 1'b1;
         end
      end
   end

   // Per-item working registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      rd_idx_ff     <= rd_idx_in;
      ev_idx_ff     <= ev_idx_in;
      hit_ff        <= hit_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      if (rd_en) begin
         rd_id_vld_ff <= id_vld_ff[rd_addr];
         rd_pd_vld_ff <= pd_vld_ff[rd_addr];
      end
   end

   // Output register: hold a result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff   <= emit_kind;
         rsp_target_ff <= emit_target;
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.kind      = rsp_kind_ff;
   assign rsp.target_id = rsp_target_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.last      = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/client_heartbeat_table.sv =====
// ----------------------------------------------------------------------------
// client_heartbeat_table: keepalive table of registered client ids
// Request items (tick, register, unregister, pong) go in on req; one or more
// result items per request come out on rsp, the final one marked by last.
// Three registers (tick_step, ping_period, ping_stamp) sit on the APB port
// at byte addresses 0, 4 and 8.
//
// A request is queued, then the engine walks the SLOTS entries of the
// table one per cycle, holding while rsp stalls, through the registered
// read port of the slot RAMs. Register, unregister and pong walk the table
// (unregister and pong stop at the first match); a tick without a sweep
// skips the walk, and a sweep gives a ping or drop result per registered id.
// The engine takes a new request only when done with the last one. A
// two-entry queue lets requests arrive while the engine works.
// Reset empties the table at once (per-entry valid bits, no clearing pass),
// loads the register defaults and the countdown. When rsp stalls, the walk
// holds on the entry whose result waits; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module client_heartbeat_table #(
   parameter int SLOTS = cht_pkg::SLOTS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   cht_req_if.sink                          req,
   cht_rsp_if.source                        rsp,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [cht_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [cht_pkg::DATA_W-1:0]  pwdata,
   output logic      [cht_pkg::DATA_W-1:0]  prdata,
   output logic                             pready
);
   import cht_pkg::*;

   logic [STEP_W-1:0]   tick_step_ff;
   logic [PERIOD_W-1:0] ping_period_ff;
   logic [STAMP_W-1:0]  ping_stamp_ff;
   logic                csr_write;
   logic [1:0]          csr_index;
   cfg_type             cfg;
   item_type            q_item;
   logic                q_valid;
   logic                q_pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_step_ff   <= TICK_STEP_RESET;
         ping_period_ff <= PING_PERIOD_RESET;
         ping_stamp_ff  <= PING_STAMP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TICK_STEP:   tick_step_ff   <= pwdata[STEP_W-1:0];
            REG_PING_PERIOD: ping_period_ff <= pwdata[PERIOD_W-1:0];
            REG_PING_STAMP:  ping_stamp_ff  <= pwdata[STAMP_W-1:0];
            default: ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      unique case (csr_index)
         REG_TICK_STEP:   prdata = DATA_W'(tick_step_ff);
         REG_PING_PERIOD: prdata = DATA_W'(ping_period_ff);
         REG_PING_STAMP:  prdata = DATA_W'(ping_stamp_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.tick_step   = tick_step_ff;
   assign cfg.ping_period = ping_period_ff;
   assign cfg.ping_stamp  = ping_stamp_ff;

   cht_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   cht_back #(.SLOTS(SLOTS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

   // The engine only takes an item the queue holds
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("engine popped an empty queue");

   // Reset loads the register defaults
   a_reset_defaults: assert property (@(posedge clock)
      reset |=> (tick_step_ff == TICK_STEP_RESET) &&
                (ping_period_ff == PING_PERIOD_RESET) &&
                (ping_stamp_ff == PING_STAMP_RESET))
      else $error("register defaults not loaded by reset");

   // A write to the ping stamp register lands in the next cycle
   a_stamp_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_index == REG_PING_STAMP)) |=>
         (ping_stamp_ff == $past(pwdata[STAMP_W-1:0])))
      else $error("ping stamp write lost");

endmodule

`default_nettype wire
